// ----- design/rfd_pkg.sv -----
`default_nettype none

package rfd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] MAX_DATA_RESET = 8'd128;

  // frame layout
  localparam logic [7:0] POS_HEADER = 8'd0;
  localparam logic [7:0] POS_DEVICE = 8'd1;
  localparam logic [7:0] POS_REG_HI = 8'd2;
  localparam logic [7:0] POS_REG_LO = 8'd3;
  localparam logic [7:0] POS_DATA   = 8'd4;
  localparam logic [7:0] MIN_FRAME  = 8'd7;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd6;
  localparam logic [7:0] COUNT_MAX  = 8'd255;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_FMT = 2'd2,
    ST_BAD_CRC = 2'd3
  } status_t;

  // one byte of crc-16/modbus, reflected, lsb first
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/rfd_in_if.sv -----
`default_nettype none

interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- design/rfd_out_if.sv -----
`default_nettype none

interface rfd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [6:0]  data_index;
  logic [1:0]  status;
  logic [7:0]  device_addr;
  logic [15:0] reg_addr;

  modport source (output valid, output kind, output data_byte, output data_index,
                  output status, output device_addr, output reg_addr, input ready);
  modport sink   (input valid, input kind, input data_byte, input data_index,
                  input status, input device_addr, input reg_addr, output ready);
endinterface

`default_nettype wire

// ----- design/response_frame_deframer_core.sv -----
// Response frame deframer with crc-16/modbus check.
// in_chan carries one frame byte per beat (rx_byte) and frame_end on the last
// byte. out_chan carries result beats: a provisional data byte (kind 0) for
// every data-field byte that does not end the frame, and one status beat (kind 1) on the final byte.
// Bytes outside the data field that do not end the frame give no result.
// cfg_we/cfg_wdata write max_data_bytes; write it only while the block is idle.
// Throughput: one byte per cycle while results are taken. The crc byte update,
// the field capture and the status checks sit between the accept edge and the
// result register, and a result is valid the cycle after its byte is accepted.
// in_chan.ready is high whenever the result register is empty or being taken
// this cycle, so a stalled receiver holds back at most one result and then
// stalls the sender; nothing is dropped.
// Reset (rst_n low, synchronous) clears the frame state, empties the result
// register and sets max_data_bytes to 128.
`default_nettype none

module response_frame_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rfd_in_if.sink           in_chan,
  rfd_out_if.source        out_chan,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  logic [7:0]  max_data_r;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  header_r, header_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [15:0] reg_r, reg_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  data_byte_r, data_byte_nxt;
  logic [6:0]  data_index_r, data_index_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [7:0]  out_dev_r, out_dev_nxt;
  logic [15:0] out_reg_r, out_reg_nxt;

  logic        in_fire, out_fire, emit, in_data;
  logic [7:0]  pos, count_inc, data_len, b;
  logic [8:0]  data_end;
  rfd_pkg::status_t st;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_valid_r && out_chan.ready;
  assign in_chan.ready = !out_valid_r || out_chan.ready;

  assign b   = in_chan.rx_byte;
  assign pos = byte_count_r;

  always_comb begin
    header_nxt = (pos == rfd_pkg::POS_HEADER) ? b : header_r;
    dev_nxt    = (pos == rfd_pkg::POS_DEVICE) ? b : dev_r;
    reg_nxt    = reg_r;
    if (pos == rfd_pkg::POS_REG_HI) begin
      reg_nxt[15:8] = b;
    end
    if (pos == rfd_pkg::POS_REG_LO) begin
      reg_nxt[7:0] = b;
    end
    crc_nxt   = rfd_pkg::crc_update(crc_r, b);
    count_inc = (byte_count_r == rfd_pkg::COUNT_MAX) ? byte_count_r : byte_count_r + 8'd1;

    data_len = {1'b0, header_nxt[6:0]} + 8'd1;
    data_end = {1'b0, rfd_pkg::POS_DATA} + {1'b0, data_len};
    in_data  = (pos >= rfd_pkg::POS_DATA) && ({1'b0, pos} < data_end);

    if (count_inc < rfd_pkg::MIN_FRAME) begin
      st = rfd_pkg::ST_BAD_LEN;
    end else if (header_nxt[7]) begin
      st = rfd_pkg::ST_BAD_FMT;
    end else if (({1'b0, count_inc} != {1'b0, data_len} + rfd_pkg::FRAME_OVERHEAD)
                 || (max_data_r < data_len)) begin
      st = rfd_pkg::ST_BAD_LEN;
    end else if (crc_nxt != 16'h0000) begin
      st = rfd_pkg::ST_BAD_CRC;
    end else begin
      st = rfd_pkg::ST_OK;
    end

    emit = in_chan.frame_end || in_data;

    kind_nxt       = in_chan.frame_end ? rfd_pkg::KIND_STATUS : rfd_pkg::KIND_DATA;
    data_byte_nxt  = in_chan.frame_end ? 8'h00 : b;
    data_index_nxt = in_chan.frame_end ? 7'd0 : 7'(pos - rfd_pkg::POS_DATA);
    status_nxt     = in_chan.frame_end ? st : rfd_pkg::ST_OK;
    out_dev_nxt    = dev_nxt;
    out_reg_nxt    = reg_nxt;

    out_valid_nxt = out_valid_r && !out_fire;
    if (in_fire && emit) begin
      out_valid_nxt = 1'b1;
    end

    if (!in_fire) begin
      byte_count_nxt = byte_count_r;
    end else if (in_chan.frame_end) begin
      byte_count_nxt = 8'd0;
    end else begin
      byte_count_nxt = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_data_r   <= rfd_pkg::MAX_DATA_RESET;
      byte_count_r <= 8'd0;
      crc_r        <= rfd_pkg::CRC_INIT;
      header_r     <= 8'h00;
      dev_r        <= 8'h00;
      reg_r        <= 16'h0000;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_data_r <= cfg_wdata;
      end
      byte_count_r <= byte_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (in_fire) begin
        if (in_chan.frame_end) begin
          crc_r    <= rfd_pkg::CRC_INIT;
          header_r <= 8'h00;
          dev_r    <= 8'h00;
          reg_r    <= 16'h0000;
        end else begin
          crc_r    <= crc_nxt;
          header_r <= header_nxt;
          dev_r    <= dev_nxt;
          reg_r    <= reg_nxt;
        end
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      kind_r       <= kind_nxt;
      data_byte_r  <= data_byte_nxt;
      data_index_r <= data_index_nxt;
      status_r     <= status_nxt;
      out_dev_r    <= out_dev_nxt;
      out_reg_r    <= out_reg_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = kind_r;
  assign out_chan.data_byte   = data_byte_r;
  assign out_chan.data_index  = data_index_r;
  assign out_chan.status      = status_r;
  assign out_chan.device_addr = out_dev_r;
  assign out_chan.reg_addr    = out_reg_r;

  // frame state returns to reset after the final byte
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.frame_end) |=> (byte_count_r == 8'd0 && crc_r == rfd_pkg::CRC_INIT
                                        && header_r == 8'h00))
    else $error("frame state not cleared after final byte");

  // byte count saturates
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_chan.frame_end && byte_count_r == rfd_pkg::COUNT_MAX)
      |=> (byte_count_r == rfd_pkg::COUNT_MAX))
    else $error("byte count wrapped");

  // every final byte yields a status beat
  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.frame_end) |=> (out_valid_r && kind_r == rfd_pkg::KIND_STATUS))
    else $error("final byte gave no status beat");

  // a data beat never carries a status code
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == rfd_pkg::KIND_DATA) |-> (status_r == rfd_pkg::ST_OK))
    else $error("data beat with nonzero status");

  // a held result is not overwritten while stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input taken while result stalled");

endmodule

`default_nettype wire

// ----- dv/frame_result_checker.sv -----
module frame_result_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  rfd_in_if               in_mon,
  rfd_out_if              out_mon,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  output int              fail_count,
  output int              pending_count
);

  typedef struct packed {
    logic             kind;
    logic [7:0]       data_byte;
    logic [6:0]       data_index;
    rfd_pkg::status_t status;
    logic [7:0]       device_addr;
    logic [15:0]      reg_addr;
  } frame_result_t;

  logic [7:0]    data_limit;
  logic [7:0]    bytes_seen;
  logic [15:0]   crc_acc;
  logic [7:0]    hdr_byte;
  logic [7:0]    dev_addr;
  logic [15:0]   reg_word;
  frame_result_t predicted_beats[$];

  // bitwise form: the input byte is folded in one bit per shift
  function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ b[k]) ? ((r >> 1) ^ rfd_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_frame();
    bytes_seen = '0;
    crc_acc    = rfd_pkg::CRC_INIT;
    hdr_byte   = '0;
    dev_addr   = '0;
    reg_word   = '0;
  endfunction

  // advances the frame state by one byte; returns 1 when the byte yields a result beat
  function automatic logic deframe_byte(input logic [7:0] b, input logic last,
                                        output frame_result_t r);
    logic [7:0] pos;
    logic [8:0] data_len;
    pos = bytes_seen;
    crc_acc = modbus_crc_step(crc_acc, b);
    case (pos)
      rfd_pkg::POS_HEADER: hdr_byte = b;
      rfd_pkg::POS_DEVICE: dev_addr = b;
      rfd_pkg::POS_REG_HI: reg_word[15:8] = b;
      rfd_pkg::POS_REG_LO: reg_word[7:0] = b;
      default: ;
    endcase
    if (bytes_seen != rfd_pkg::COUNT_MAX) bytes_seen = bytes_seen + 8'd1;
    data_len = {2'b00, hdr_byte[6:0]} + 9'd1;
    r = '0;
    r.status      = rfd_pkg::ST_OK;
    r.device_addr = dev_addr;
    r.reg_addr    = reg_word;
    if (!last) begin
      if (pos >= rfd_pkg::POS_DATA && {1'b0, pos} < {1'b0, rfd_pkg::POS_DATA} + data_len) begin
        r.kind       = rfd_pkg::KIND_DATA;
        r.data_byte  = b;
        r.data_index = 7'(pos - rfd_pkg::POS_DATA);
        return 1'b1;
      end
      return 1'b0;
    end
    r.kind = rfd_pkg::KIND_STATUS;
    if (bytes_seen < rfd_pkg::MIN_FRAME) begin
      r.status = rfd_pkg::ST_BAD_LEN;
    end else if (hdr_byte[7]) begin
      r.status = rfd_pkg::ST_BAD_FMT;
    end else if ({1'b0, bytes_seen} != data_len + rfd_pkg::FRAME_OVERHEAD ||
                 {1'b0, data_limit} < data_len) begin
      r.status = rfd_pkg::ST_BAD_LEN;
    end else if (crc_acc != 16'h0000) begin
      r.status = rfd_pkg::ST_BAD_CRC;
    end
    clear_frame();
    return 1'b1;
  endfunction

  function automatic int field_mismatch(input string what, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    frame_result_t want;
    frame_result_t got;
    int errs;
    errs = 0;
    if (!rst_n) begin
      clear_frame();
      data_limit = rfd_pkg::MAX_DATA_RESET;
      predicted_beats.delete();
    end else begin
      if (cfg_we) data_limit = cfg_wdata;
      // compare before predicting: a beat taken now cannot belong to a byte taken now
      if (out_mon.valid && out_mon.ready) begin
        got.kind        = out_mon.kind;
        got.data_byte   = out_mon.data_byte;
        got.data_index  = out_mon.data_index;
        got.status      = rfd_pkg::status_t'(out_mon.status);
        got.device_addr = out_mon.device_addr;
        got.reg_addr    = out_mon.reg_addr;
        if (predicted_beats.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual %p", $time, got);
          errs++;
        end else begin
          want = predicted_beats.pop_front();
          errs += field_mismatch("kind", 16'(want.kind), 16'(got.kind));
          errs += field_mismatch("data_byte", 16'(want.data_byte), 16'(got.data_byte));
          errs += field_mismatch("data_index", 16'(want.data_index), 16'(got.data_index));
          errs += field_mismatch("status", 16'(want.status), 16'(got.status));
          errs += field_mismatch("device_addr", 16'(want.device_addr),
                                 16'(got.device_addr));
          errs += field_mismatch("reg_addr", want.reg_addr, got.reg_addr);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (deframe_byte(in_mon.rx_byte, in_mon.frame_end, want)) predicted_beats.push_back(want);
      end
    end
    fail_count    <= fail_count + errs;
    pending_count <= predicted_beats.size();
  end

endmodule

// ----- dv/tb_response_frame_deframer_core.sv -----
module tb_response_frame_deframer_core;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         fail_count;
  int         pending_count;
  bit         calm;
  logic [7:0] frame_q[$];
  logic [7:0] cur_limit;
  int         phase_beats;

  rfd_in_if  in_chan ();
  rfd_out_if out_chan ();

  response_frame_deframer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  frame_result_checker result_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #600000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: ready runs broken up by stall bursts
  initial begin
    forever begin
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    in_chan.valid     <= 1'b1;
    in_chan.rx_byte   <= b;
    in_chan.frame_end <= last;
    do @(posedge clk); while (!in_chan.ready);
    phase_beats++;
  endtask

  task automatic hold_off(input int cycles);
    in_chan.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_frame();
    bit gappy;
    gappy = !calm && $urandom_range(0, 2) != 0;
    foreach (frame_q[i]) begin
      if (gappy && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 17));
      send_beat(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // block is idle once every result beat is in and the result register is empty
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit = v;
  endtask

  function automatic void append_crc();
    logic [15:0] c;
    c = rfd_pkg::CRC_INIT;
    foreach (frame_q[i]) c = rfd_pkg::crc_update(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endfunction

  function automatic void fill_random(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void make_frame(input logic cmd, input int data_len);
    frame_q.delete();
    frame_q.push_back({cmd, 7'(data_len - 1)});
    fill_random(3 + data_len);
    append_crc();
  endfunction

  // mostly short data fields; near the limit only when the limit is small
  function automatic int pick_data_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 6);
    if (r < 95) begin
      if (cur_limit >= 8'd1 && cur_limit <= 8'd32)
        return int'(cur_limit) + int'($urandom_range(0, 2)) - 1 + ((cur_limit == 8'd1) ? 1 : 0);
      return $urandom_range(1, 6);
    end
    return $urandom_range(1, 128);
  endfunction

  function automatic void make_random_frame();
    int pick;
    int n;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      make_frame(1'b0, pick_data_len());
    end else if (pick < 65) begin
      make_frame(1'b0, pick_data_len());
      k = $urandom_range(1, frame_q.size() - 1);
      frame_q[k] ^= 8'(1 << $urandom_range(0, 7));
    end else if (pick < 73) begin
      make_frame(1'b1, pick_data_len());
    end else if (pick < 83) begin
      // length mismatch: cut the tail or pad past the crc
      make_frame(1'b0, pick_data_len());
      n = $urandom_range(1, 4);
      if ($urandom_range(0, 1) == 0) repeat (n) void'(frame_q.pop_back());
      else fill_random(n);
    end else if (pick < 90) begin
      frame_q.delete();
      fill_random($urandom_range(1, 6));
    end else begin
      frame_q.delete();
      fill_random($urandom_range(1, 20));
    end
  endfunction

  initial begin : stimulus
    logic [7:0] phase_limits[6];
    in_chan.valid     <= 1'b0;
    in_chan.rx_byte   <= 8'h00;
    in_chan.frame_end <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 8'h00;
    rst_n             <= 1'b0;
    cur_limit = rfd_pkg::MAX_DATA_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // lone byte with the command bit: short frame wins
    frame_q = '{8'hFF};
    send_frame();
    // minimal good frame, all-ones addresses
    frame_q = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    append_crc();
    send_frame();
    // command bit set with a valid crc
    frame_q = '{8'h80, 8'h00, 8'h00, 8'h00, 8'hFF};
    append_crc();
    send_frame();
    // crc high byte corrupted
    frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    append_crc();
    frame_q[6] ^= 8'h80;
    send_frame();

    phase_limits = '{8'd1, 8'd0, 8'd255, 8'($urandom_range(2, 12)),
                     8'($urandom_range(0, 255)), rfd_pkg::MAX_DATA_RESET};
    foreach (phase_limits[p]) begin
      drain();
      if (p == 5) calm <= 1'b1;
      write_limit(phase_limits[p]);
      phase_beats = 0;
      if (p == 2) begin
        // overlong frame: byte count saturates
        frame_q.delete();
        fill_random($urandom_range(256, 300));
        frame_q[0][7] = 1'b0;
        send_frame();
      end
      while (phase_beats < 100) begin
        make_random_frame();
        send_frame();
      end
    end
    drain();

    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rfd_pkg.sv
design/rfd_in_if.sv
design/rfd_out_if.sv
design/response_frame_deframer_core.sv
dv/frame_result_checker.sv
dv/tb_response_frame_deframer_core.sv
